// ----- rtl/core/mccp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the Clarke/Park current converter.
package mccp_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MAC,
      ST_SQRT,
      ST_DONE
   } state_type;

   // Configuration register indexes
   localparam int CsrIdxW = 3;
   localparam logic [CsrIdxW-1:0] CSR_CURRENT_SCALE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_COEF_A_FROM_A = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_COEF_A_FROM_B = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COEF_B_FROM_A = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_COEF_B_FROM_B = 3'd4;

   localparam logic signed [15:0] SCALE_RESET = 16'sd16384;
   localparam logic signed [15:0] CAA_RESET   = 16'sd16455;
   localparam logic signed [15:0] CAB_RESET   = -16'sd3;
   localparam logic signed [15:0] CBA_RESET   = 16'sd361;
   localparam logic signed [15:0] CBB_RESET   = 16'sd16718;

   localparam logic signed [17:0] INV_SQRT3_Q14     = 18'sd9459;
   localparam logic signed [17:0] TWO_INV_SQRT3_Q14 = 18'sd18919;
   localparam logic signed [17:0] CORDIC_GAIN_INV   = 18'sd9949;
   localparam logic [4:0] CORDIC_LAST = 5'd13;
   localparam logic [3:0] MAC_LAST    = 4'd13;
   localparam logic [4:0] SQRT_LAST   = 5'd16;
   // Offset average steps on the shared multiplier, one per channel
   localparam logic [3:0] DIV_A_STEP  = 4'd14;
   localparam logic [3:0] DIV_B_STEP  = 4'd15;

   localparam int ReqDataW = 40;
   localparam int RspDataW = 80;
   localparam int CountW   = 10;
   localparam int SumW     = 22;
   localparam int NumW     = 28;

   // Arctangent table, Q2.14 in units of a quarter turn
   function automatic logic signed [16:0] atan_q14(input logic [3:0] i);
      logic signed [16:0] r;
      unique case (i)
         4'd0:    r = 17'sd8192;
         4'd1:    r = 17'sd4836;
         4'd2:    r = 17'sd2555;
         4'd3:    r = 17'sd1297;
         4'd4:    r = 17'sd651;
         4'd5:    r = 17'sd326;
         4'd6:    r = 17'sd163;
         4'd7:    r = 17'sd81;
         4'd8:    r = 17'sd41;
         4'd9:    r = 17'sd20;
         4'd10:   r = 17'sd10;
         4'd11:   r = 17'sd5;
         4'd12:   r = 17'sd3;
         4'd13:   r = 17'sd1;
         default: r = 17'sd0;
      endcase
      return r;
   endfunction

   // Round half up by 2^14
   function automatic logic signed [37:0] rnd14(input logic signed [37:0] v);
      return (v + 38'sd8192) >>> 14;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
      logic signed [15:0] r;
      if (v > 38'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -38'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/motor_current_clarke_park.sv -----
`timescale 1ns / 1ps
// Top level: two-phase current scaling, correction, Clarke/Park transform and offset calibration.
//
//  channel  | direction | handshake          | contents
//  req_     | in        | tvalid/tready      | tdata {angle, adc_b, adc_a}, tuser operation
//  rsp_     | out       | tvalid/tready      | tdata {dc, q, d, phase_b, phase_a}, tuser offsets_updated
//  csr_     | in        | csr_we, no wait    | csr_index, csr_wdata (16-bit signed Q2.14)
//
// A convert transaction passes through a load, 14 CORDIC iterations, 14 multiply-accumulate
// steps on the single 30x30 multiplier and 17 square-root iterations before it reaches
// the output register. A calibration sample goes to DONE once it is accumulated; the one
// that completes the average first runs one reciprocal multiply per channel.
// Reset is synchronous, active high; it restores register defaults and clears offsets.
// The input is taken only in IDLE; a finished result parks in the output register, so a
// new transaction is accepted while it waits. A stalled output holds the sequencer in DONE.
module motor_current_clarke_park #(
   parameter int CALIB_SAMPLES = 1000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [11:0] adc_a, [23:12] adc_b, [39:24] angle
   input  logic [mccp_pkg::ReqDataW-1:0]    req_tdata,
   // [0] operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] phase_a_current, [31:16] phase_b_current, [47:32] d_current,
   // [63:48] q_current, [79:64] dc_current
   output logic [mccp_pkg::RspDataW-1:0]    rsp_tdata,
   // [0] offsets_updated
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [mccp_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [15:0]                      csr_wdata
);
   import mccp_pkg::*;

   // Averaging numerator stays below 2^27, so a reciprocal with 27 + log2(N) fraction
   // bits gives the exact quotient
   localparam int MulW     = 30;
   localparam int DivShift = 27 + $clog2(CALIB_SAMPLES);
   localparam logic [63:0] DivRecip =
      ((64'd1 << DivShift) + 64'(CALIB_SAMPLES - 1)) / 64'(CALIB_SAMPLES);
   localparam logic signed [MulW-1:0] DivMul = MulW'(DivRecip);
   localparam logic [NumW-1:0]   NHalf   = NumW'(CALIB_SAMPLES / 2);
   localparam logic [CountW:0]   NCount  = (CountW + 1)'(CALIB_SAMPLES);

   state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        phase_ff, phase_in;
   logic [4:0]  iter_ff, iter_in;

   logic signed [15:0] scale_ff, scale_in, caa_ff, caa_in, cab_ff, cab_in;
   logic signed [15:0] cba_ff, cba_in, cbb_ff, cbb_in;
   logic [15:0]        offset_a_ff, offset_a_in, offset_b_ff, offset_b_in;
   logic [SumW-1:0]    sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CountW-1:0]  count_ff, count_in;

   logic signed [17:0] da_ff, da_in, db_ff, db_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [17:0] x_ff, x_in, y_ff, y_in, c_ff, c_in, s_ff, s_in;
   logic signed [16:0] z_ff, z_in;
   logic signed [2*MulW-1:0] prod_ff, prod_in;
   logic signed [37:0] acc_ff, acc_in;
   logic signed [15:0] sa_ff, sa_in, sb_ff, sb_in, pa_ff, pa_in, pb_ff, pb_in;
   logic signed [15:0] d_ff, d_in, q_ff, q_in;
   logic signed [17:0] be_ff, be_in;
   logic               qpos_ff, qpos_in;
   logic [33:0]        rad_ff, rad_in, res_ff, res_in, bit_ff, bit_in;
   logic [NumW-1:0]    num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic               calib_ff, calib_in, upd_ff, upd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_upd_ff, rsp_upd_in;

   // Combinational working values
   logic signed [MulW-1:0] mult_a, mult_b;
   logic signed [17:0] al, xn, yn;
   logic signed [16:0] zn;
   logic signed [37:0] prod_ext, rounded;
   logic [34:0]        sq_trial;
   logic [SumW:0]      sum_new_a, sum_new_b;
   logic [16:0]        mag;
   logic signed [15:0] dc;

   assign al = {{2{pa_ff[15]}}, pa_ff};
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_upd_ff;

   // Shared multiplier operand select, one product per MAC step
   always_comb begin
      unique case (step_ff)
         4'd0:    begin mult_a = MulW'(da_ff); mult_b = MulW'(scale_ff); end
         4'd1:    begin mult_a = MulW'(db_ff); mult_b = MulW'(scale_ff); end
         4'd2:    begin mult_a = MulW'(caa_ff); mult_b = MulW'(sa_ff); end
         4'd3:    begin mult_a = MulW'(cab_ff); mult_b = MulW'(sb_ff); end
         4'd4:    begin mult_a = MulW'(cba_ff); mult_b = MulW'(sa_ff); end
         4'd5:    begin mult_a = MulW'(cbb_ff); mult_b = MulW'(sb_ff); end
         4'd6:    begin mult_a = MulW'(INV_SQRT3_Q14); mult_b = MulW'(pa_ff); end
         4'd7:    begin mult_a = MulW'(TWO_INV_SQRT3_Q14); mult_b = MulW'(pb_ff); end
         4'd8:    begin mult_a = MulW'(al); mult_b = MulW'(c_ff); end
         4'd9:    begin mult_a = MulW'(be_ff); mult_b = MulW'(s_ff); end
         4'd10:   begin mult_a = MulW'(be_ff); mult_b = MulW'(c_ff); end
         4'd11:   begin mult_a = MulW'(al); mult_b = MulW'(s_ff); end
         4'd12:   begin mult_a = MulW'(al); mult_b = MulW'(al); end
         4'd13:   begin mult_a = MulW'(be_ff); mult_b = MulW'(be_ff); end
         DIV_A_STEP: begin mult_a = MulW'(num_a_ff); mult_b = DivMul; end
         DIV_B_STEP: begin mult_a = MulW'(num_b_ff); mult_b = DivMul; end
      endcase
   end

   always_comb begin
      // hold by default; the output valid drops once it is taken
      state_in = state_ff;   step_in = step_ff;   phase_in = phase_ff; iter_in = iter_ff;
      scale_in = scale_ff;   caa_in = caa_ff;     cab_in = cab_ff;
      cba_in = cba_ff;       cbb_in = cbb_ff;
      offset_a_in = offset_a_ff; offset_b_in = offset_b_ff;
      sum_a_in = sum_a_ff;   sum_b_in = sum_b_ff; count_in = count_ff;
      da_in = da_ff;         db_in = db_ff;       quad_in = quad_ff;
      x_in = x_ff;           y_in = y_ff;         z_in = z_ff;
      c_in = c_ff;           s_in = s_ff;
      prod_in = prod_ff;     acc_in = acc_ff;
      sa_in = sa_ff;         sb_in = sb_ff;       pa_in = pa_ff;    pb_in = pb_ff;
      d_in = d_ff;           q_in = q_ff;         be_in = be_ff;    qpos_in = qpos_ff;
      rad_in = rad_ff;       res_in = res_ff;     bit_in = bit_ff;
      num_a_in = num_a_ff;   num_b_in = num_b_ff;
      calib_in = calib_ff;   upd_in = upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_upd_in = rsp_upd_ff;

      prod_ext = prod_ff[37:0];
      rounded = '0;
      xn = x_ff; yn = y_ff; zn = z_ff;
      sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};
      sum_new_a = {1'b0, sum_a_ff} + (SumW + 1)'(req_tdata[11:0]);
      sum_new_b = {1'b0, sum_b_ff} + (SumW + 1)'(req_tdata[23:12]);
      mag = res_ff[16:0];

      // saturate the signed magnitude; q of exactly zero takes the negative sign
      if (qpos_ff) begin
         dc = (mag > 17'd32767) ? 16'sh7fff : 16'(mag);
      end else begin
         dc = (mag > 17'd32768) ? 16'sh8000 : 16'(-mag);
      end

      // register writes take effect whenever they arrive
      if (csr_we) begin
         unique case (csr_index)
            CSR_CURRENT_SCALE: scale_in = csr_wdata;
            CSR_COEF_A_FROM_A: caa_in = csr_wdata;
            CSR_COEF_A_FROM_B: cab_in = csr_wdata;
            CSR_COEF_B_FROM_A: cba_in = csr_wdata;
            CSR_COEF_B_FROM_B: cbb_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               iter_in = '0;
               calib_in = req_tuser;
               upd_in = 1'b0;
               if (req_tuser) begin
                  // calibration sample: accumulate, average when the run is full
                  if (({1'b0, count_ff} + 1'b1) >= NCount) begin
                     num_a_in = NumW'({sum_new_a, 4'b0000}) + NHalf;
                     num_b_in = NumW'({sum_new_b, 4'b0000}) + NHalf;
                     sum_a_in = '0;
                     sum_b_in = '0;
                     count_in = '0;
                     upd_in = 1'b1;
                     step_in = DIV_A_STEP;
                     phase_in = 1'b0;
                     state_in = ST_MAC;
                  end else begin
                     sum_a_in = sum_new_a[SumW-1:0];
                     sum_b_in = sum_new_b[SumW-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = ST_DONE;
                  end
               end else begin
                  da_in = $signed({2'b00, req_tdata[11:0], 4'b0000})
                        - $signed({2'b00, offset_a_ff});
                  db_in = $signed({2'b00, req_tdata[23:12], 4'b0000})
                        - $signed({2'b00, offset_b_ff});
                  quad_in = req_tdata[39:38];
                  x_in = CORDIC_GAIN_INV;
                  y_in = '0;
                  z_in = $signed({3'b000, req_tdata[37:24]});
                  state_in = ST_CORDIC;
               end
            end
         end

         ST_CORDIC: begin
            if (!z_ff[16]) begin
               xn = x_ff - (y_ff >>> iter_ff[3:0]);
               yn = y_ff + (x_ff >>> iter_ff[3:0]);
               zn = z_ff - atan_q14(iter_ff[3:0]);
            end else begin
               xn = x_ff + (y_ff >>> iter_ff[3:0]);
               yn = y_ff - (x_ff >>> iter_ff[3:0]);
               zn = z_ff + atan_q14(iter_ff[3:0]);
            end
            x_in = xn;
            y_in = yn;
            z_in = zn;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == CORDIC_LAST) begin
               // fold into the quadrant given by the top angle bits
               unique case (quad_ff)
                  2'd0: begin c_in = xn;  s_in = yn;  end
                  2'd1: begin c_in = -yn; s_in = xn;  end
                  2'd2: begin c_in = -xn; s_in = -yn; end
                  2'd3: begin c_in = yn;  s_in = -xn; end
               endcase
               step_in = '0;
               phase_in = 1'b0;
               state_in = ST_MAC;
            end
         end

         ST_MAC: begin
            if (!phase_ff) begin
               prod_in = mult_a * mult_b;
               phase_in = 1'b1;
            end else begin
               if (step_ff < 4'd2 || !step_ff[0]) begin
                  acc_in = prod_ext;
               end else if (step_ff == 4'd11) begin
                  acc_in = acc_ff - prod_ext;
               end else begin
                  acc_in = acc_ff + prod_ext;
               end
               rounded = rnd14(acc_in);
               unique case (step_ff)
                  4'd0:    sa_in = sat16(rounded);
                  4'd1:    sb_in = sat16(rounded);
                  4'd3:    pa_in = sat16(rounded);
                  4'd5:    pb_in = sat16(rounded);
                  4'd7:    be_in = rounded[17:0];
                  4'd9:    d_in = sat16(rounded);
                  4'd11:   begin
                     q_in = sat16(rounded);
                     qpos_in = (rounded > 38'sd0);
                  end
                  4'd13:   rad_in = acc_in[33:0];
                  // quotient of the reciprocal multiply, kept to the offset width
                  DIV_A_STEP: offset_a_in = prod_ff[DivShift +: 16];
                  DIV_B_STEP: offset_b_in = prod_ff[DivShift +: 16];
                  default: ;
               endcase
               phase_in = 1'b0;
               step_in = step_ff + 1'b1;
               if (step_ff == MAC_LAST) begin
                  res_in = '0;
                  bit_in = 34'h1_0000_0000;
                  iter_in = '0;
                  state_in = ST_SQRT;
               end else if (step_ff == DIV_B_STEP) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SQRT: begin
            if ({1'b0, rad_ff} >= sq_trial) begin
               rad_in = rad_ff - sq_trial[33:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == SQRT_LAST) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // advance only when the output register is free or draining
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_upd_in = upd_ff;
               rsp_data_in = calib_ff ? '0 : {dc, q_ff, d_ff, pb_ff, pa_ff};
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         phase_ff <= 1'b0;
         iter_ff <= '0;
         scale_ff <= SCALE_RESET;
         caa_ff <= CAA_RESET;
         cab_ff <= CAB_RESET;
         cba_ff <= CBA_RESET;
         cbb_ff <= CBB_RESET;
         offset_a_ff <= '0;
         offset_b_ff <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         phase_ff <= phase_in;
         iter_ff <= iter_in;
         scale_ff <= scale_in;
         caa_ff <= caa_in;
         cab_ff <= cab_in;
         cba_ff <= cba_in;
         cbb_ff <= cbb_in;
         offset_a_ff <= offset_a_in;
         offset_b_ff <= offset_b_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath, no reset needed
   always_ff @(posedge clock) begin
      da_ff <= da_in;
      db_ff <= db_in;
      quad_ff <= quad_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      c_ff <= c_in;
      s_ff <= s_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      d_ff <= d_in;
      q_ff <= q_in;
      be_ff <= be_in;
      qpos_ff <= qpos_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      calib_ff <= calib_in;
      upd_ff <= upd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_upd_ff <= rsp_upd_in;
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a transaction is in flight");

   a_calib_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("offset update carries nonzero currents");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) < CALIB_SAMPLES)
      else $error("calibration count passed the run length");
`endif

endmodule
